FILE: rtl/voxel_face_visibility_macros.svh
// Assertion macros for the voxel face visibility checker.
`ifndef VOXEL_FACE_VISIBILITY_MACROS_SVH
`define VOXEL_FACE_VISIBILITY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VFV_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("voxel face visibility check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VFV_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("voxel face visibility check failed");

`endif

FILE: rtl/vfv_pkg.sv
// Shared types and constants of the voxel face visibility block.
package vfv_pkg;

    // Default chunk dimensions
    localparam int CHUNK_WIDTH_DEF  = 16;
    localparam int CHUNK_HEIGHT_DEF = 64;

    // Payload field widths
    localparam int X_W    = 4;
    localparam int Y_W    = 6;
    localparam int Z_W    = 4;
    localparam int ID_W   = 8;
    localparam int FACE_COUNT = 6;

    // Function codes of an input item
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Voxel selected by the address unit: the voxel itself or one neighbor
    typedef enum logic [2:0] {
        SEL_HERE = 3'd0,
        SEL_PX   = 3'd1,
        SEL_NX   = 3'd2,
        SEL_PY   = 3'd3,
        SEL_NY   = 3'd4,
        SEL_PZ   = 3'd5,
        SEL_NZ   = 3'd6
    } face_sel_t;

    // Last step of a query: collect only, no read issued
    localparam logic [2:0] STEP_LAST = 3'd7;

endpackage

FILE: rtl/vfv_if.sv
// Handshake channels for command and response items.
interface vfv_cmd_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [vfv_pkg::X_W-1:0]     x_pos;
    logic [vfv_pkg::Y_W-1:0]     y_pos;
    logic [vfv_pkg::Z_W-1:0]     z_pos;
    logic [vfv_pkg::ID_W-1:0]    block_id;

    modport source (output valid, func, x_pos, y_pos, z_pos, block_id, input ready);
    modport sink   (input valid, func, x_pos, y_pos, z_pos, block_id, output ready);
endinterface

interface vfv_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [vfv_pkg::FACE_COUNT-1:0] face_mask;
    logic                          solid_here;

    modport source (output valid, face_mask, solid_here, input ready);
    modport sink   (input valid, face_mask, solid_here, output ready);
endinterface

FILE: rtl/voxel_face_visibility.sv
// Top level of the voxel face visibility block: sequencer, voxel RAM and neighbor unit.
//
// Keeps one solid bit per voxel of a CHUNK_WIDTH x CHUNK_HEIGHT x CHUNK_WIDTH chunk in a
// single-port RAM. After reset a clearing pass writes all CHUNK_WIDTH*CHUNK_HEIGHT*CHUNK_WIDTH
// voxels (16384 at the defaults) empty, one per cycle, with cmd.ready low.
// A write item gives no response. A query item runs through the accept cycle, seven RAM
// reads, one per cycle, for the voxel and its six neighbors, a step that collects the last
// read data, and a step that loads the response register; the single RAM port sets this
// sequence of reads.
// A pending response that is not taken holds the next query in its final cycle only.
// face_mask bits: 0 +x, 1 -x, 2 +y, 3 -y, 4 +z, 5 -z; border faces are never visible.
module voxel_face_visibility #(
    parameter int CHUNK_WIDTH  = vfv_pkg::CHUNK_WIDTH_DEF,
    parameter int CHUNK_HEIGHT = vfv_pkg::CHUNK_HEIGHT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    vfv_cmd_if.sink   cmd,
    vfv_rsp_if.source rsp
);

    localparam int DEPTH  = CHUNK_WIDTH * CHUNK_HEIGHT * CHUNK_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_WRITE  = 5'b00100,
        ST_QUERY  = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [ADDR_W-1:0]               clr_cnt_reg, clr_cnt_next;
    logic [2:0]                      step_reg, step_next;
    logic                            pend_ok_reg, pend_ok_next;
    logic                            here_reg, here_next;
    logic [vfv_pkg::FACE_COUNT-1:0]  mask_reg, mask_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    logic [vfv_pkg::FACE_COUNT-1:0]  rsp_mask_reg, rsp_mask_next;
    logic                            rsp_solid_reg, rsp_solid_next;

    logic [vfv_pkg::X_W-1:0]         x_reg;
    logic [vfv_pkg::Y_W-1:0]         y_reg;
    logic [vfv_pkg::Z_W-1:0]         z_reg;
    logic                            solid_wr_reg;

    logic                            cmd_acc;
    logic                            unit_inside;
    logic [ADDR_W-1:0]               unit_addr;
    logic                            ram_we;
    logic [ADDR_W-1:0]               ram_addr;
    logic                            ram_wdata;
    logic                            ram_rdata;
    logic [2:0]                      col_idx;
    logic [2:0]                      face_bit;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;

    // Shared neighbor unit, selected by the step count
    vfv_addr_unit #(
        .CHUNK_WIDTH  (CHUNK_WIDTH),
        .CHUNK_HEIGHT (CHUNK_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_addr (
        .x_pos    (x_reg),
        .y_pos    (y_reg),
        .z_pos    (z_reg),
        .sel      (vfv_pkg::face_sel_t'(step_reg)),
        .in_chunk (unit_inside),
        .addr     (unit_addr)
    );

    // Steer the RAM port between clearing, writes and query reads
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_reg;
            ram_wdata = 1'b0;
        end
        else
        begin
            ram_we    = (state_reg == ST_WRITE) && unit_inside;
            ram_addr  = unit_addr;
            ram_wdata = solid_wr_reg;
        end
    end

    vfv_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Index of the read whose data arrives this cycle
    assign col_idx  = step_reg - 3'd1;
    assign face_bit = col_idx - 3'd1;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        step_next      = step_reg;
        pend_ok_next   = pend_ok_reg;
        here_next      = here_reg;
        mask_next      = mask_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_mask_next  = rsp_mask_reg;
        rsp_solid_next = rsp_solid_reg;

        // Drop the response once taken
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    step_next    = 3'd0;
                    pend_ok_next = 1'b0;
                    here_next    = 1'b0;
                    mask_next    = '0;
                    state_next   = (cmd.func == vfv_pkg::FUNC_WRITE) ? ST_WRITE : ST_QUERY;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_QUERY:
            begin
                // Collect the read issued in the previous step
                if (step_reg != 3'd0)
                begin
                    if (col_idx == 3'd0)
                    begin
                        here_next = pend_ok_reg && ram_rdata;
                    end
                    else
                    begin
                        mask_next[face_bit] = pend_ok_reg && !ram_rdata;
                    end
                end
                // Issue the next read, or finish
                pend_ok_next = unit_inside;
                if (step_reg == vfv_pkg::STEP_LAST)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_RESULT:
            begin
                // Load the response once the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_mask_next  = mask_reg & {vfv_pkg::FACE_COUNT{here_reg}};
                    rsp_solid_next = here_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            step_reg      <= '0;
            pend_ok_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            step_reg      <= step_next;
            pend_ok_reg   <= pend_ok_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        here_reg      <= here_next;
        mask_reg      <= mask_next;
        rsp_mask_reg  <= rsp_mask_next;
        rsp_solid_reg <= rsp_solid_next;
        if (cmd_acc)
        begin
            x_reg        <= cmd.x_pos;
            y_reg        <= cmd.y_pos;
            z_reg        <= cmd.z_pos;
            solid_wr_reg <= (cmd.block_id != '0);
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.face_mask  = rsp_mask_reg;
    assign rsp.solid_here = rsp_solid_reg;

endmodule

FILE: rtl/vfv_ram.sv
// Generic single-port RAM with registered read.
module vfv_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/vfv_addr_unit.sv
// Shared neighbor unit: offsets a voxel, checks the chunk bounds, forms the address.
module vfv_addr_unit #(
    parameter int CHUNK_WIDTH  = vfv_pkg::CHUNK_WIDTH_DEF,
    parameter int CHUNK_HEIGHT = vfv_pkg::CHUNK_HEIGHT_DEF,
    parameter int ADDR_W       = 14
) (
    input  logic [vfv_pkg::X_W-1:0] x_pos,
    input  logic [vfv_pkg::Y_W-1:0] y_pos,
    input  logic [vfv_pkg::Z_W-1:0] z_pos,
    input  vfv_pkg::face_sel_t      sel,
    output logic                    in_chunk,
    output logic [ADDR_W-1:0]       addr
);

    localparam int PLANE = CHUNK_WIDTH * CHUNK_HEIGHT;

    logic [vfv_pkg::X_W:0] nx;
    logic [vfv_pkg::Y_W:0] ny;
    logic [vfv_pkg::Z_W:0] nz;
    logic                  under;
    logic                  sel_ok;
    logic [31:0]           addr_full;

    // Step to the selected neighbor, flag a step below zero
    always_comb
    begin
        nx     = {1'b0, x_pos};
        ny     = {1'b0, y_pos};
        nz     = {1'b0, z_pos};
        under  = 1'b0;
        sel_ok = 1'b1;
        case (sel)
            vfv_pkg::SEL_HERE: ;
            vfv_pkg::SEL_PX: nx = {1'b0, x_pos} + (vfv_pkg::X_W+1)'(1);
            vfv_pkg::SEL_NX:
            begin
                under = (x_pos == '0);
                nx    = {1'b0, x_pos} - (vfv_pkg::X_W+1)'(1);
            end
            vfv_pkg::SEL_PY: ny = {1'b0, y_pos} + (vfv_pkg::Y_W+1)'(1);
            vfv_pkg::SEL_NY:
            begin
                under = (y_pos == '0);
                ny    = {1'b0, y_pos} - (vfv_pkg::Y_W+1)'(1);
            end
            vfv_pkg::SEL_PZ: nz = {1'b0, z_pos} + (vfv_pkg::Z_W+1)'(1);
            vfv_pkg::SEL_NZ:
            begin
                under = (z_pos == '0);
                nz    = {1'b0, z_pos} - (vfv_pkg::Z_W+1)'(1);
            end
            default: sel_ok = 1'b0;
        endcase
    end

    // Bounds check and linear address, z-major then y then x
    assign in_chunk = sel_ok && !under &&
                      (int'(nx) < CHUNK_WIDTH) &&
                      (int'(ny) < CHUNK_HEIGHT) &&
                      (int'(nz) < CHUNK_WIDTH);

    assign addr_full = 32'(nz) * 32'(PLANE) + 32'(ny) * 32'(CHUNK_WIDTH) + 32'(nx);
    assign addr      = in_chunk ? addr_full[ADDR_W-1:0] : '0;

endmodule

FILE: rtl/vfv_checker.sv
// Port-level checks of the voxel face visibility block, bound to the top level.
`include "voxel_face_visibility_macros.svh"

module vfv_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cmd_valid,
    input logic                           cmd_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [vfv_pkg::FACE_COUNT-1:0] face_mask,
    input logic                           solid_here
);

    // Hold a response until it is taken
    `VFV_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // One item at a time: busy right after an accept
    `VFV_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)

    // An empty voxel shows no faces
    `VFV_ASSERT_IMPLIES(a_empty_no_faces, clk, rst_n, rsp_valid && !solid_here,
        face_mask == '0)

    // A fresh response never appears in the cycle after an accept
    `VFV_ASSERT_NEXT(a_no_rsp_after_accept, clk, rst_n,
        cmd_valid && cmd_ready && !rsp_valid, !rsp_valid)

endmodule

bind voxel_face_visibility vfv_checker u_vfv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .face_mask  (rsp.face_mask),
    .solid_here (rsp.solid_here)
);

FILE: sim/tb_voxel_face_visibility.sv
// Self-checking testbench for the voxel face visibility block: writes, queries, face masks.
module tb_voxel_face_visibility;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW           = vfv_pkg::CHUNK_WIDTH_DEF;
    localparam int CH           = vfv_pkg::CHUNK_HEIGHT_DEF;
    localparam int RANDOM_ITEMS = 775;
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_REPORTS  = 10;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DIRECTED_N   = 25;

    // One command item, with an optional typed-in expected result for queries
    typedef struct packed {
        logic                           func;
        logic [vfv_pkg::X_W-1:0]        x_pos;
        logic [vfv_pkg::Y_W-1:0]        y_pos;
        logic [vfv_pkg::Z_W-1:0]        z_pos;
        logic [vfv_pkg::ID_W-1:0]       block_id;
        logic                           typed;
        logic [vfv_pkg::FACE_COUNT-1:0] face_mask;
        logic                           solid_here;
    } voxel_cmd_t;

    typedef struct packed {
        logic [vfv_pkg::FACE_COUNT-1:0] face_mask;
        logic                           solid_here;
    } face_result_t;

    logic clk = 1'b0;
    logic rst_n;

    vfv_cmd_if cmd_ch ();
    vfv_rsp_if rsp_ch ();

    voxel_face_visibility dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the chunk, indexed [x][y][z]; starts empty like the block after reset
    bit occupancy [CW][CH][CW];

    face_result_t face_results_due [$];
    int           error_count = 0;
    int           cycle_count = 0;
    bit           no_stall    = 1'b0;

    // Directed table: mask bits are +x,-x,+y,-y,+z,-z from bit 0 up
    voxel_cmd_t directed_rows [DIRECTED_N] = '{
        // queries right after reset see an empty chunk; block id is ignored
        '{vfv_pkg::FUNC_QUERY, 4'd0,  6'd0,  4'd0,  8'h00, 1'b1, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_QUERY, 4'd15, 6'd63, 4'd15, 8'hFF, 1'b1, 6'b000000, 1'b0},
        // low corner: border faces hidden, inner faces open
        '{vfv_pkg::FUNC_WRITE, 4'd0,  6'd0,  4'd0,  8'h01, 1'b0, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_QUERY, 4'd0,  6'd0,  4'd0,  8'h00, 1'b1, 6'b010101, 1'b1},
        // high corner
        '{vfv_pkg::FUNC_WRITE, 4'd15, 6'd63, 4'd15, 8'hFF, 1'b0, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_QUERY, 4'd15, 6'd63, 4'd15, 8'h00, 1'b1, 6'b101010, 1'b1},
        // isolated interior voxel, then enclose it one neighbor at a time
        '{vfv_pkg::FUNC_WRITE, 4'd7,  6'd31, 4'd7,  8'h80, 1'b0, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_QUERY, 4'd7,  6'd31, 4'd7,  8'h00, 1'b1, 6'b111111, 1'b1},
        '{vfv_pkg::FUNC_WRITE, 4'd8,  6'd31, 4'd7,  8'h02, 1'b0, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_QUERY, 4'd7,  6'd31, 4'd7,  8'h00, 1'b0, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_WRITE, 4'd6,  6'd31, 4'd7,  8'h03, 1'b0, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_WRITE, 4'd7,  6'd32, 4'd7,  8'h04, 1'b0, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_WRITE, 4'd7,  6'd30, 4'd7,  8'h05, 1'b0, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_WRITE, 4'd7,  6'd31, 4'd8,  8'h06, 1'b0, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_WRITE, 4'd7,  6'd31, 4'd6,  8'h07, 1'b0, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_QUERY, 4'd7,  6'd31, 4'd7,  8'h5A, 1'b0, 6'b000000, 1'b0},
        // clear it again: an empty voxel shows no faces
        '{vfv_pkg::FUNC_WRITE, 4'd7,  6'd31, 4'd7,  8'h00, 1'b0, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_QUERY, 4'd7,  6'd31, 4'd7,  8'h00, 1'b1, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_QUERY, 4'd8,  6'd31, 4'd7,  8'h00, 1'b0, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_WRITE, 4'd0,  6'd0,  4'd0,  8'h00, 1'b0, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_QUERY, 4'd0,  6'd0,  4'd0,  8'h00, 1'b1, 6'b000000, 1'b0},
        // two more corners on the border
        '{vfv_pkg::FUNC_WRITE, 4'd15, 6'd0,  4'd0,  8'h55, 1'b0, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_QUERY, 4'd15, 6'd0,  4'd0,  8'h00, 1'b0, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_WRITE, 4'd0,  6'd63, 4'd15, 8'hAA, 1'b0, 6'b000000, 1'b0},
        '{vfv_pkg::FUNC_QUERY, 4'd0,  6'd63, 4'd15, 8'h00, 1'b0, 6'b000000, 1'b0}
    };

    always #4 clk = ~clk;

    function automatic bit in_chunk(input int x, input int y, input int z);
        return x >= 0 && x < CW && y >= 0 && y < CH && z >= 0 && z < CW;
    endfunction

    function automatic bit occupied(input int x, input int y, input int z);
        if (!in_chunk(x, y, z))
            return 1'b0;
        return occupancy[x][y][z];
    endfunction

    // Open faces of one voxel against the shadow chunk
    function automatic face_result_t predict_faces(input int x, input int y, input int z);
        face_result_t res;
        int           nx;
        int           ny;
        int           nz;
        res.face_mask  = '0;
        res.solid_here = occupied(x, y, z);
        if (res.solid_here)
        begin
            for (int f = 0; f < vfv_pkg::FACE_COUNT; f++)
            begin
                nx = x + int'(f == 0) - int'(f == 1);
                ny = y + int'(f == 2) - int'(f == 3);
                nz = z + int'(f == 4) - int'(f == 5);
                if (in_chunk(nx, ny, nz) && !occupied(nx, ny, nz))
                    res.face_mask[f] = 1'b1;
            end
        end
        return res;
    endfunction

    // Mostly no gap or a short one, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    // Present one item, hold it until accepted, then update the shadow chunk or queue the expected result
    task automatic send_item(input voxel_cmd_t row, input int gap);
        face_result_t res;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.func     <= row.func;
        cmd_ch.x_pos    <= row.x_pos;
        cmd_ch.y_pos    <= row.y_pos;
        cmd_ch.z_pos    <= row.z_pos;
        cmd_ch.block_id <= row.block_id;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (row.func == vfv_pkg::FUNC_WRITE)
        begin
            if (in_chunk(int'(row.x_pos), int'(row.y_pos), int'(row.z_pos)))
                occupancy[row.x_pos][row.y_pos][row.z_pos] = (row.block_id != '0);
        end
        else
        begin
            if (row.typed)
            begin
                res.face_mask  = row.face_mask;
                res.solid_here = row.solid_here;
            end
            else
                res = predict_faces(int'(row.x_pos), int'(row.y_pos), int'(row.z_pos));
            face_results_due.push_back(res);
        end
    endtask

    // Cycle budget for the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, face_results_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Response side: check each accepted result, then pick the next ready level
    initial
    begin : rsp_side
        face_result_t due;
        int           hold_left;
        logic         ready_next;
        hold_left     = 0;
        ready_next    = 1'b0;
        rsp_ch.ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (face_results_due.size() == 0)
                    flag_error($sformatf("result with nothing pending: mask %b solid %b",
                                         rsp_ch.face_mask, rsp_ch.solid_here));
                else
                begin
                    due = face_results_due.pop_front();
                    if (rsp_ch.face_mask !== due.face_mask)
                        flag_error($sformatf("face_mask expected %b got %b",
                                             due.face_mask, rsp_ch.face_mask));
                    if (rsp_ch.solid_here !== due.solid_here)
                        flag_error($sformatf("solid_here expected %b got %b",
                                             due.solid_here, rsp_ch.solid_here));
                end
            end
            if (no_stall)
                rsp_ch.ready <= 1'b1;
            else
            begin
                if (hold_left == 0)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        ready_next = 1'b1;
                        hold_left  = $urandom_range(1, 16);
                    end
                    else
                    begin
                        ready_next = 1'b0;
                        hold_left  = idle_len() + 1;
                    end
                end
                rsp_ch.ready <= ready_next;
                hold_left--;
            end
        end
    end

    // Command side: reset, directed table, then random items
    initial
    begin : cmd_side
        voxel_cmd_t row;
        int         region;
        int         base_x;
        int         base_y;
        int         base_z;
        int         gap;
        region          = 4;
        base_x          = 0;
        base_y          = 0;
        base_z          = 0;
        rst_n           = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.func     = vfv_pkg::FUNC_WRITE;
        cmd_ch.x_pos    = '0;
        cmd_ch.y_pos    = '0;
        cmd_ch.z_pos    = '0;
        cmd_ch.block_id = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < DIRECTED_N; i++)
            send_item(directed_rows[i], idle_len());

        // Random items, mostly clustered in small cubes so writes and queries meet
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
            begin
                region = $urandom_range(0, 4);
                case (region)
                    0:
                    begin
                        base_x = 0;
                        base_y = 0;
                        base_z = 0;
                    end
                    1:
                    begin
                        base_x = CW - 4;
                        base_y = CH - 4;
                        base_z = CW - 4;
                    end
                    default:
                    begin
                        base_x = $urandom_range(1, CW - 5);
                        base_y = $urandom_range(1, CH - 5);
                        base_z = $urandom_range(1, CW - 5);
                    end
                endcase
            end
            no_stall = (i >= 200 && i < 300);

            row.func = ($urandom_range(0, 99) < 55) ? vfv_pkg::FUNC_WRITE : vfv_pkg::FUNC_QUERY;
            if (region == 4)
            begin
                row.x_pos = (vfv_pkg::X_W)'($urandom_range(0, CW - 1));
                row.y_pos = (vfv_pkg::Y_W)'($urandom_range(0, CH - 1));
                row.z_pos = (vfv_pkg::Z_W)'($urandom_range(0, CW - 1));
            end
            else
            begin
                row.x_pos = (vfv_pkg::X_W)'(base_x + int'($urandom_range(0, 3)));
                row.y_pos = (vfv_pkg::Y_W)'(base_y + int'($urandom_range(0, 3)));
                row.z_pos = (vfv_pkg::Z_W)'(base_z + int'($urandom_range(0, 3)));
            end
            row.block_id   = ($urandom_range(0, 99) < 30) ? 8'h00 : 8'($urandom_range(1, 255));
            row.typed      = 1'b0;
            row.face_mask  = '0;
            row.solid_here = 1'b0;

            gap = no_stall ? 0 : idle_len();
            // Once mid-run: hold the sender until every pending result is back
            if (i == 450)
            begin
                cmd_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (face_results_due.size() != 0);
                gap = 0;
            end
            send_item(row, gap);
        end
        cmd_ch.valid <= 1'b0;
        no_stall = 1'b0;

        // Drain outstanding results, then let the last item settle
        while (face_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (face_results_due.size() != 0)
            flag_error($sformatf("%0d results never arrived", face_results_due.size()));

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: voxel_face_visibility.f
+incdir+rtl
rtl/vfv_pkg.sv
rtl/vfv_if.sv
rtl/vfv_ram.sv
rtl/vfv_addr_unit.sv
rtl/voxel_face_visibility.sv
rtl/vfv_checker.sv
sim/tb_voxel_face_visibility.sv
